@@ design/pevr_pkg.sv @@
// pevr_pkg: shared types and constants of the pointer event reporter
// event type and code values, register indexes, sequencer states, divider request
`timescale 1ns / 1ps

package pevr_pkg;

  localparam int unsigned POS_W   = 16;
  localparam int unsigned PROD_W  = 2 * POS_W;
  localparam int unsigned BTN_W   = 5;
  localparam int unsigned NSLOT   = 8;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned STEP_W  = 5;

  localparam logic [1:0] EV_SYNC = 2'd0;
  localparam logic [1:0] EV_KEY  = 2'd1;
  localparam logic [1:0] EV_REL  = 2'd2;
  localparam logic [1:0] EV_ABS  = 2'd3;

  localparam logic [8:0] CODE_LEFT   = 9'h110;
  localparam logic [8:0] CODE_RIGHT  = 9'h111;
  localparam logic [8:0] CODE_MIDDLE = 9'h112;
  localparam logic [8:0] CODE_WHEEL  = 9'h008;
  localparam logic [8:0] CODE_X      = 9'h000;
  localparam logic [8:0] CODE_Y      = 9'h001;
  localparam logic [8:0] CODE_SYNC   = 9'h000;

  localparam logic [15:0] WHEEL_UP   = 16'h0001;
  localparam logic [15:0] WHEEL_DOWN = 16'hffff;

  localparam logic [1:0] REG_DRIVER_READY  = 2'd0;
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;

  localparam logic [15:0] WIDTH_RESET  = 16'd1024;
  localparam logic [15:0] HEIGHT_RESET = 16'd768;

  // burst slots, in emission order
  localparam logic [SLOT_W-1:0] SLOT_LEFT   = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_MIDDLE = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_RIGHT  = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_UP     = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_DOWN   = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_X      = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_Y      = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_SYNC   = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [POS_W-1:0]  divisor;
  } div_req_t;

endpackage

@@ design/pointer_event_reporter_unit.sv @@
// pointer_event_reporter_unit: top level, sequencer, scaling and event output register
// depends on pevr_pkg and pevr_div
`timescale 1ns / 1ps

//  channel   | signals                                          | direction
//  ----------+--------------------------------------------------+----------
//  sample    | in_valid, in_ready, button_bits, x/y_position    | in
//  event     | out_valid, out_ready, event_type/code/value/last | out
//  config    | cfg_write, cfg_index, cfg_data                   | in
//
// a request with driver_ready low is accepted and yields nothing
// otherwise each axis passes in turn through the shared multiply and 16-step divider,
// then the burst of 3 to 8 events leaves at one per cycle while out_ready is high
// in_ready is high only while the sequencer is idle; a held last event does not block it
// rst clears control state, registers to their reset values and the button history

module pointer_event_reporter_unit #(
  parameter int unsigned AXIS_MAX = 32767
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [4:0]         button_bits,
  input  logic [15:0]        x_position,
  input  logic [15:0]        y_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         event_type,
  output logic [8:0]         event_code,
  output logic signed [15:0] event_value,
  output logic               last_event,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam logic [pevr_pkg::POS_W-1:0] AxisK = pevr_pkg::POS_W'(AXIS_MAX);

  pevr_pkg::state_t state, state_next;

  logic                          driver_ready;
  logic [pevr_pkg::POS_W-1:0]    screen_width;
  logic [pevr_pkg::POS_W-1:0]    screen_height;
  logic [pevr_pkg::BTN_W-1:0]    prev_buttons;
  logic [pevr_pkg::BTN_W-1:0]    buttons;
  logic [pevr_pkg::POS_W-1:0]    xpos;
  logic [pevr_pkg::POS_W-1:0]    ypos;
  logic                          axis;
  logic                          zero_size;
  logic [pevr_pkg::PROD_W-1:0]   prod;
  logic [pevr_pkg::POS_W-1:0]    divisor;
  logic [pevr_pkg::POS_W-1:0]    xval;
  logic [pevr_pkg::POS_W-1:0]    yval;
  logic [pevr_pkg::NSLOT-1:0]    pending;

  logic                          accept;
  logic                          load_event;
  logic [pevr_pkg::BTN_W-1:0]    changed;
  logic [pevr_pkg::POS_W-1:0]    size_sel;
  logic [pevr_pkg::POS_W-1:0]    pos_sel;
  logic [pevr_pkg::POS_W-1:0]    top;
  logic [pevr_pkg::POS_W-1:0]    pos_cl;
  logic                          size_small;
  logic [pevr_pkg::SLOT_W-1:0]   slot;
  logic [pevr_pkg::POS_W-1:0]    axis_val;
  logic                          div_done;
  logic [pevr_pkg::POS_W-1:0]    div_q;
  pevr_pkg::div_req_t            div_req;

  logic [1:0]                    ev_type;
  logic [8:0]                    ev_code;
  logic [15:0]                   ev_value;

  pevr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  assign accept     = in_valid && in_ready;
  assign changed    = button_bits ^ prev_buttons;
  assign size_sel   = axis ? screen_height : screen_width;
  assign pos_sel    = axis ? ypos : xpos;
  assign size_small = size_sel <= pevr_pkg::POS_W'(1);
  assign top        = size_sel - pevr_pkg::POS_W'(1);
  assign pos_cl     = size_small ? '0 : ((pos_sel > top) ? top : pos_sel);
  assign axis_val   = zero_size ? '0 : div_q;

  always_comb begin
    slot = pevr_pkg::SLOT_SYNC;
    for (int i = pevr_pkg::NSLOT - 1; i >= 0; i--) begin
      if (pending[i]) begin
        slot = pevr_pkg::SLOT_W'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pevr_pkg::ST_IDLE: begin
        if (accept && driver_ready) begin
          state_next = pevr_pkg::ST_MUL;
        end
      end
      pevr_pkg::ST_MUL: begin
        state_next = pevr_pkg::ST_DIV_GO;
      end
      pevr_pkg::ST_DIV_GO: begin
        state_next = pevr_pkg::ST_DIV_WAIT;
      end
      pevr_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = axis ? pevr_pkg::ST_EMIT : pevr_pkg::ST_MUL;
        end
      end
      pevr_pkg::ST_EMIT: begin
        if (load_event && (slot == pevr_pkg::SLOT_SYNC)) begin
          state_next = pevr_pkg::ST_IDLE;
        end
      end
      default: state_next = pevr_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready         = 1'b0;
    load_event       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod;
    div_req.divisor  = divisor;
    unique case (state)
      pevr_pkg::ST_IDLE:     in_ready = 1'b1;
      pevr_pkg::ST_MUL:      ;
      pevr_pkg::ST_DIV_GO:   div_req.start = 1'b1;
      pevr_pkg::ST_DIV_WAIT: ;
      pevr_pkg::ST_EMIT:     load_event = (!out_valid || out_ready) && (pending != '0);
      default:               ;
    endcase
  end

  always_comb begin
    ev_type  = pevr_pkg::EV_SYNC;
    ev_code  = pevr_pkg::CODE_SYNC;
    ev_value = '0;
    unique case (slot)
      pevr_pkg::SLOT_LEFT: begin
        ev_type  = pevr_pkg::EV_KEY;
        ev_code  = pevr_pkg::CODE_LEFT;
        ev_value = 16'(buttons[0]);
      end
      pevr_pkg::SLOT_MIDDLE: begin
        ev_type  = pevr_pkg::EV_KEY;
        ev_code  = pevr_pkg::CODE_MIDDLE;
        ev_value = 16'(buttons[1]);
      end
      pevr_pkg::SLOT_RIGHT: begin
        ev_type  = pevr_pkg::EV_KEY;
        ev_code  = pevr_pkg::CODE_RIGHT;
        ev_value = 16'(buttons[2]);
      end
      pevr_pkg::SLOT_UP: begin
        ev_type  = pevr_pkg::EV_REL;
        ev_code  = pevr_pkg::CODE_WHEEL;
        ev_value = pevr_pkg::WHEEL_UP;
      end
      pevr_pkg::SLOT_DOWN: begin
        ev_type  = pevr_pkg::EV_REL;
        ev_code  = pevr_pkg::CODE_WHEEL;
        ev_value = pevr_pkg::WHEEL_DOWN;
      end
      pevr_pkg::SLOT_X: begin
        ev_type  = pevr_pkg::EV_ABS;
        ev_code  = pevr_pkg::CODE_X;
        ev_value = xval;
      end
      pevr_pkg::SLOT_Y: begin
        ev_type  = pevr_pkg::EV_ABS;
        ev_code  = pevr_pkg::CODE_Y;
        ev_value = yval;
      end
      pevr_pkg::SLOT_SYNC: begin
        ev_type  = pevr_pkg::EV_SYNC;
        ev_code  = pevr_pkg::CODE_SYNC;
        ev_value = '0;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pevr_pkg::ST_IDLE;
      driver_ready  <= 1'b0;
      screen_width  <= pevr_pkg::WIDTH_RESET;
      screen_height <= pevr_pkg::HEIGHT_RESET;
      prev_buttons  <= '0;
      pending       <= '0;
      axis          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          pevr_pkg::REG_DRIVER_READY:  driver_ready  <= cfg_data[0];
          pevr_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
          pevr_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
          default: ;
        endcase
      end
      if (accept && driver_ready) begin
        prev_buttons <= button_bits;
        axis         <= 1'b0;
        pending      <= {3'b111, changed[4] & button_bits[4],
                         changed[3] & button_bits[3], changed[2:0]};
      end else if ((state == pevr_pkg::ST_DIV_WAIT) && div_done) begin
        axis <= 1'b1;
      end else if (load_event) begin
        pending[slot] <= 1'b0;
      end
      if (load_event) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      buttons <= button_bits;
      xpos    <= x_position;
      ypos    <= y_position;
    end
    if (state == pevr_pkg::ST_MUL) begin
      prod      <= {16'b0, pos_cl} * {16'b0, AxisK};
      divisor   <= top;
      zero_size <= size_small;
    end
    if ((state == pevr_pkg::ST_DIV_WAIT) && div_done) begin
      if (axis) begin
        yval <= axis_val;
      end else begin
        xval <= axis_val;
      end
    end
    if (load_event) begin
      event_type  <= ev_type;
      event_code  <= ev_code;
      event_value <= ev_value;
      last_event  <= (slot == pevr_pkg::SLOT_SYNC);
    end
  end

endmodule

@@ design/pevr_div.sv @@
// pevr_div: iterative restoring divider, one quotient bit per cycle
// quotient is known to fit in 16 bits; depends on pevr_pkg
`timescale 1ns / 1ps

module pevr_div (
  input  logic                          clk,
  input  logic                          rst,
  input  pevr_pkg::div_req_t            req,
  output logic                          done,
  output logic [pevr_pkg::POS_W-1:0]    quotient
);

  logic [pevr_pkg::POS_W-1:0]  rem;
  logic [pevr_pkg::POS_W-1:0]  dq;
  logic [pevr_pkg::POS_W-1:0]  divisor;
  logic [pevr_pkg::STEP_W-1:0] cnt;
  logic [pevr_pkg::POS_W:0]    trial;
  logic                        fits;

  assign trial    = {rem, dq[pevr_pkg::POS_W-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == pevr_pkg::STEP_W'(1));
      if (req.start) begin
        cnt <= pevr_pkg::STEP_W'(pevr_pkg::POS_W);
      end else if (cnt != '0) begin
        cnt <= cnt - pevr_pkg::STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.dividend[pevr_pkg::PROD_W-1:pevr_pkg::POS_W];
      dq      <= req.dividend[pevr_pkg::POS_W-1:0];
      divisor <= req.divisor;
    end else if (cnt != '0) begin
      if (fits) begin
        rem <= pevr_pkg::POS_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[pevr_pkg::POS_W-1:0];
      end
      dq <= {dq[pevr_pkg::POS_W-2:0], fits};
    end
  end

endmodule

@@ tb/sv/tb_pointer_event_reporter_unit.sv @@
// tb_pointer_event_reporter_unit: self-checking bench for the pointer event reporter
// scoreboard class predicts each event burst; tasks drive samples and config, an initial block drives back-pressure
// depends on pevr_pkg and pointer_event_reporter_unit
`timescale 1ns / 1ps

module tb_pointer_event_reporter_unit;
  import pevr_pkg::*;

  localparam int unsigned AXIS_LIMIT = 32767;
  localparam int unsigned SETTLE_CYCLES = 64;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [4:0]         button_bits;
  logic [15:0]        x_position;
  logic [15:0]        y_position;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         event_type;
  logic [8:0]         event_code;
  logic signed [15:0] event_value;
  logic               last_event;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  bit hold_req;

  typedef struct {
    logic [1:0]  kind;
    logic [8:0]  code;
    logic [15:0] value;
    logic        last;
  } pointer_event_t;

  class event_scoreboard;
    bit             ready;
    logic [15:0]    width;
    logic [15:0]    height;
    logic [4:0]     prev_buttons;
    pointer_event_t burst_q[$];
    int             errors;

    function new();
      ready = 1'b0;
      width = WIDTH_RESET;
      height = HEIGHT_RESET;
      prev_buttons = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_DRIVER_READY: ready = data[0];
        REG_SCREEN_WIDTH: width = data;
        REG_SCREEN_HEIGHT: height = data;
        default: ;
      endcase
    endfunction

    function logic [15:0] scale_axis(logic [15:0] pos, logic [15:0] size);
      longint unsigned top;
      longint unsigned p;
      if (size <= 1) return '0;
      top = size - 1;
      p = pos;
      if (p > top) p = top;
      return 16'((p * AXIS_LIMIT) / top);
    endfunction

    function void push(logic [1:0] kind, logic [8:0] code, logic [15:0] value, logic last);
      pointer_event_t ev;
      ev.kind = kind;
      ev.code = code;
      ev.value = value;
      ev.last = last;
      burst_q.push_back(ev);
    endfunction

    function void note_request(logic [4:0] b, logic [15:0] x, logic [15:0] y);
      logic [4:0] changed;
      if (!ready) return;
      changed = b ^ prev_buttons;
      if (changed[0]) push(EV_KEY, CODE_LEFT, {15'd0, b[0]}, 1'b0);
      if (changed[1]) push(EV_KEY, CODE_MIDDLE, {15'd0, b[1]}, 1'b0);
      if (changed[2]) push(EV_KEY, CODE_RIGHT, {15'd0, b[2]}, 1'b0);
      if (changed[3] && b[3]) push(EV_REL, CODE_WHEEL, WHEEL_UP, 1'b0);
      if (changed[4] && b[4]) push(EV_REL, CODE_WHEEL, WHEEL_DOWN, 1'b0);
      push(EV_ABS, CODE_X, scale_axis(x, width), 1'b0);
      push(EV_ABS, CODE_Y, scale_axis(y, height), 1'b0);
      push(EV_SYNC, CODE_SYNC, 16'd0, 1'b1);
      prev_buttons = b;
    endfunction

    function void compare(string what, logic [15:0] exp, logic [15:0] act);
      if (exp !== act) begin
        errors++;
        if (errors <= 40)
          $display("%0t %s: expected %0h, got %0h", $time, what, exp, act);
      end
    endfunction

    function void check_event(logic [1:0] t, logic [8:0] c, logic [15:0] v, logic l);
      pointer_event_t ev;
      if (burst_q.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t unexpected event: expected none, got type %0d code %0h value %0h",
                   $time, t, c, v);
        return;
      end
      ev = burst_q.pop_front();
      compare("event_type", 16'(ev.kind), 16'(t));
      compare("event_code", 16'(ev.code), 16'(c));
      compare("event_value", ev.value, v);
      compare("last_event", 16'(ev.last), 16'(l));
    endfunction

    function int pending();
      return burst_q.size();
    endfunction
  endclass

  event_scoreboard sb;

  pointer_event_reporter_unit #(
    .AXIS_MAX(AXIS_LIMIT)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .button_bits(button_bits),
    .x_position(x_position),
    .y_position(y_position),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_type(event_type),
    .event_code(event_code),
    .event_value(event_value),
    .last_event(last_event),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(button_bits, x_position, y_position);
      if (out_valid && out_ready) sb.check_event(event_type, event_code, event_value, last_event);
    end
  end

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 1));
      1: return 16'hffff;
      2: return 16'($urandom_range(2, 16));
      default: return 16'($urandom_range(2, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_pos(logic [15:0] size);
    int s;
    s = size;
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return (s <= 1) ? 16'd0 : 16'($urandom_range(0, s - 1));
      2: return (s == 0) ? 16'd0 : 16'(s - 1 + $urandom_range(0, 1));
      default: return 16'($urandom_range(0, s));
    endcase
  endfunction

  function automatic logic [4:0] next_buttons(logic [4:0] b);
    if ($urandom_range(0, 1)) return b ^ (5'd1 << $urandom_range(0, 4));
    return 5'($urandom_range(0, 31));
  endfunction

  task automatic send_sample(logic [4:0] b, logic [15:0] x, logic [15:0] y, bit calm);
    int gap;
    gap = pick_gap(calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    button_bits <= b;
    x_position <= x;
    y_position <= y;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // drop the request line and let the burst in flight drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int n;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if ($urandom_range(0, 11) == 0) begin
        out_ready <= 1'b1;
        repeat (60) @(posedge clk);
      end else begin
        n = pick_gap(1'b0);
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [4:0]  btn;
    logic [15:0] w;
    logic [15:0] h;
    bit          rdy;
    bit          calm;
    int          count;
    sb = new();
    hold_req = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    button_bits = '0;
    x_position = '0;
    y_position = '0;
    cfg_write = 1'b0;
    cfg_index = REG_DRIVER_READY;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // driver not ready out of reset: requests vanish, history stays clear
    send_sample(5'h1f, 16'hffff, 16'hffff, 1'b0);
    send_sample(5'h08, 16'd100, 16'd100, 1'b0);
    settle();

    write_reg(REG_DRIVER_READY, 16'd1);
    send_sample(5'h00, 16'd0, 16'd0, 1'b0);
    send_sample(5'h01, 16'd1023, 16'd767, 1'b0);
    send_sample(5'h03, 16'd512, 16'd384, 1'b0);
    send_sample(5'h07, 16'd1, 16'd1, 1'b0);
    send_sample(5'h00, 16'd1024, 16'd768, 1'b0);
    send_sample(5'h08, 16'd10, 16'd20, 1'b0);
    send_sample(5'h08, 16'd11, 16'd21, 1'b0);
    send_sample(5'h00, 16'd12, 16'd22, 1'b0);
    send_sample(5'h10, 16'd13, 16'd23, 1'b0);
    send_sample(5'h18, 16'd14, 16'd24, 1'b0);
    send_sample(5'h1f, 16'd15, 16'd25, 1'b0);
    send_sample(5'h00, 16'hffff, 16'hffff, 1'b0);
    send_sample(5'h1f, 16'h8000, 16'h7fff, 1'b0);
    settle();

    // ignored request keeps the button history
    write_reg(REG_DRIVER_READY, 16'd0);
    send_sample(5'h00, 16'd5, 16'd5, 1'b0);
    settle();
    write_reg(REG_DRIVER_READY, 16'hfffe);
    write_reg(REG_DRIVER_READY, 16'd1);
    send_sample(5'h1f, 16'd5, 16'd5, 1'b0);
    settle();

    // extreme sizes
    write_reg(REG_SCREEN_WIDTH, 16'd0);
    write_reg(REG_SCREEN_HEIGHT, 16'd1);
    send_sample(5'h02, 16'hffff, 16'd0, 1'b0);
    send_sample(5'h04, 16'd0, 16'hffff, 1'b0);
    settle();
    write_reg(REG_SCREEN_WIDTH, 16'hffff);
    write_reg(REG_SCREEN_HEIGHT, 16'd2);
    send_sample(5'h0a, 16'hfffe, 16'd1, 1'b0);
    send_sample(5'h15, 16'h7fff, 16'd0, 1'b0);
    settle();

    btn = 5'h15;
    for (int ph = 0; ph < 7; ph++) begin
      rdy = (ph != 3);
      w = pick_size();
      h = pick_size();
      write_reg(REG_DRIVER_READY, {15'd0, rdy});
      write_reg(REG_SCREEN_WIDTH, w);
      write_reg(REG_SCREEN_HEIGHT, h);
      if (ph == 0) hold_req = 1'b1;
      count = rdy ? 15 : 10;
      calm = 1'b0;
      for (int i = 0; i < count; i++) begin
        if (i % 10 == 0) calm = ($urandom_range(0, 3) == 0);
        btn = next_buttons(btn);
        send_sample(btn, pick_pos(w), pick_pos(h), calm);
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("[pointer_event_reporter_unit] OK");
    else
      $display("[pointer_event_reporter_unit] ERROR");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[pointer_event_reporter_unit] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
design/pevr_pkg.sv
design/pevr_div.sv
design/pointer_event_reporter_unit.sv
tb/sv/tb_pointer_event_reporter_unit.sv
